// File: hw/rtl/debug_monitor_command_parser_unit_defines.svh
// Assertion macros for the debug monitor command parser.
// Used by the RTL files that carry concurrent assertions; each expects clk and arst_n in scope.
`ifndef DEBUG_MONITOR_COMMAND_PARSER_UNIT_DEFINES_SVH
`define DEBUG_MONITOR_COMMAND_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define DMCP_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dmcp assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define DMCP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dmcp assertion failed");

`endif

// File: hw/rtl/dmcp_pkg.sv
// Package for the debug monitor command parser: types, codes and helper functions.
// No dependencies; used by the interfaces, dmcp_core and the top-level unit.
`default_nettype none

package dmcp_pkg;

	localparam int unsigned ADDR_BITS_DEF = 20;
	localparam int unsigned PART_LEN_DEF  = 256;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned DUMP_W  = 20;
	localparam int unsigned DIGIT_W = 3;
	localparam int unsigned TCNT_W  = 4;
	localparam int unsigned CFG_W   = 4;

	localparam logic [DIGIT_W-1:0] RAM_DIGITS_RST    = 3'd3;
	localparam logic [DIGIT_W-1:0] FLASH_DIGITS_RST  = 3'd4;
	localparam logic [DIGIT_W-1:0] EEPROM_DIGITS_RST = 3'd4;
	localparam logic [TCNT_W-1:0]  TIMER_COUNT_RST   = 4'd3;

	localparam logic [BYTE_W-1:0] CHR_SPACE   = 8'h20;
	localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;
	localparam logic [BYTE_W-1:0] CHR_UP_A    = "A";
	localparam logic [BYTE_W-1:0] CHR_UP_F    = "F";
	localparam logic [BYTE_W-1:0] CHR_UP_Z    = "Z";
	localparam logic [BYTE_W-1:0] CHR_LO_A    = "a";
	localparam logic [BYTE_W-1:0] CHR_LO_F    = "f";
	localparam logic [BYTE_W-1:0] CHR_ZERO    = "0";
	localparam logic [BYTE_W-1:0] CHR_NINE    = "9";
	localparam logic [BYTE_W-1:0] HEX_TEN     = 8'd10;

	localparam logic [BYTE_W-1:0] CMD_USAGE   = "?";
	localparam logic [BYTE_W-1:0] CMD_REGS    = "r";
	localparam logic [BYTE_W-1:0] CMD_IRQS    = "i";
	localparam logic [BYTE_W-1:0] CMD_WATCHES = "w";
	localparam logic [BYTE_W-1:0] CMD_FREE    = "v";
	localparam logic [BYTE_W-1:0] CMD_RAM     = "m";
	localparam logic [BYTE_W-1:0] CMD_FLASH   = "f";
	localparam logic [BYTE_W-1:0] CMD_EEPROM  = "o";
	localparam logic [BYTE_W-1:0] CMD_TIMER   = "t";
	localparam logic [BYTE_W-1:0] CMD_REPEAT  = "a";
	localparam logic [BYTE_W-1:0] CMD_CONT    = "c";
	localparam logic [BYTE_W-1:0] CMD_GO      = "g";
	localparam logic [BYTE_W-1:0] CMD_STEP    = "s";
	localparam logic [BYTE_W-1:0] CMD_NEXT    = "n";
	localparam logic [BYTE_W-1:0] CMD_ISR     = "*";

	typedef enum logic [1:0] {
		CFG_RAM_DIGITS    = 2'd0,
		CFG_FLASH_DIGITS  = 2'd1,
		CFG_EEPROM_DIGITS = 2'd2,
		CFG_TIMER_COUNT   = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ACT_NONE       = 4'd0,
		ACT_USAGE      = 4'd1,
		ACT_REGS       = 4'd2,
		ACT_IRQS       = 4'd3,
		ACT_WATCHES    = 4'd4,
		ACT_FREE_RAM   = 4'd5,
		ACT_MEM_DUMP   = 4'd6,
		ACT_TIMER_DUMP = 4'd7,
		ACT_GO         = 4'd8,
		ACT_STEP       = 4'd9,
		ACT_NEXT       = 4'd10,
		ACT_ISR_TOGGLE = 4'd11,
		ACT_UNKNOWN    = 4'd12,
		ACT_BAD_HEX    = 4'd13
	} action_t;

	typedef enum logic [1:0] {
		SPACE_RAM    = 2'd0,
		SPACE_FLASH  = 2'd1,
		SPACE_EEPROM = 2'd2
	} space_t;

	typedef enum logic [4:0] {
		MODE_IDLE   = 5'b00001,
		MODE_RAM    = 5'b00010,
		MODE_FLASH  = 5'b00100,
		MODE_EEPROM = 5'b01000,
		MODE_TIMER  = 5'b10000
	} mode_t;

	typedef enum logic [3:0] {
		LAST_NONE    = 4'd0,
		LAST_REGS    = 4'd1,
		LAST_IRQS    = 4'd2,
		LAST_WATCHES = 4'd3,
		LAST_FREE    = 4'd4,
		LAST_RAM     = 4'd5,
		LAST_FLASH   = 4'd6,
		LAST_EEPROM  = 4'd7,
		LAST_TIMER   = 4'd8
	} last_t;

	typedef struct packed {
		logic                we;
		cfg_idx_t            index;
		logic [CFG_W-1:0]    wdata;
	} cfg_wr_t;

	typedef struct packed {
		logic [BYTE_W-1:0]   echo_byte;
		action_t             action;
		space_t              mem_space;
		logic [DUMP_W-1:0]   dump_address;
		logic                prompt;
		logic                isr_debug_on;
	} result_t;

	// Returns {valid, value} for a hex digit in either case.
	function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] v;
		logic              ok;
		v  = '0;
		ok = 1'b0;
		if (c >= CHR_ZERO && c <= CHR_NINE) begin
			v  = c - CHR_ZERO;
			ok = 1'b1;
		end else if (c >= CHR_LO_A && c <= CHR_LO_F) begin
			v  = c - CHR_LO_A + HEX_TEN;
			ok = 1'b1;
		end else if (c >= CHR_UP_A && c <= CHR_UP_F) begin
			v  = c - CHR_UP_A + HEX_TEN;
			ok = 1'b1;
		end
		return {ok, v[3:0]};
	endfunction

	// Folds an upper-case letter to lower case; other bytes pass unchanged.
	function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
		if (c >= CHR_UP_A && c <= CHR_UP_Z) begin
			return c + CASE_OFFSET;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dmcp_in_if.sv
// Input channel of the debug monitor command parser: one received byte per transaction.
// Depends on dmcp_pkg.
`default_nettype none

interface dmcp_in_if;
	import dmcp_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dmcp_out_if.sv
// Result channel of the debug monitor command parser: one result per transaction.
// Depends on dmcp_pkg.
`default_nettype none

interface dmcp_out_if;
	import dmcp_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] echo_byte;
	action_t           action;
	space_t            mem_space;
	logic [DUMP_W-1:0] dump_address;
	logic              prompt;
	logic              isr_debug_on;

	modport source (output valid, output echo_byte, output action, output mem_space,
		output dump_address, output prompt, output isr_debug_on, input ready);
	modport sink (input valid, input echo_byte, input action, input mem_space,
		input dump_address, input prompt, input isr_debug_on, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dmcp_core.sv
// Parser state, configuration registers and the single-pass decode of one byte.
// Depends on dmcp_pkg and the assertion macros header.
`default_nettype none
`include "debug_monitor_command_parser_unit_defines.svh"

module dmcp_core #(
	parameter int unsigned ADDR_BITS = dmcp_pkg::ADDR_BITS_DEF,
	parameter int unsigned PART_LEN  = dmcp_pkg::PART_LEN_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire dmcp_pkg::cfg_wr_t               cfg,
	input  wire logic                            step,
	input  wire logic [dmcp_pkg::BYTE_W-1:0]     byte_s1,
	output dmcp_pkg::result_t                    res
);
	import dmcp_pkg::*;

	localparam logic [ADDR_BITS-1:0] PART_INC = ADDR_BITS'(PART_LEN);

	logic [DIGIT_W-1:0]   ram_digits_q;
	logic [DIGIT_W-1:0]   flash_digits_q;
	logic [DIGIT_W-1:0]   eeprom_digits_q;
	logic [TCNT_W-1:0]    timer_count_q;

	mode_t                mode_q, mode_d;
	last_t                last_q, last_d;
	logic [ADDR_BITS-1:0] acc_q, acc_d;
	logic [DIGIT_W-1:0]   seen_q, seen_d;
	logic [DIGIT_W-1:0]   need_q, need_d;
	logic                 flag_q, flag_d;

	logic [BYTE_W-1:0]    cmd;
	logic [4:0]           hex;
	logic [ADDR_BITS-1:0] tmr_inc;
	logic [ADDR_BITS-1:0] tmr_next;
	logic [ADDR_BITS-1:0] addr;
	action_t              act;
	space_t               space;

	// A timer index continues to the next timer and wraps at the timer count.
	assign tmr_inc  = acc_q + 1'b1;
	assign tmr_next = (tmr_inc == ADDR_BITS'(timer_count_q)) ? '0 : tmr_inc;
	assign hex      = hex_digit(byte_s1);

	always_comb begin
		mode_d = mode_q;
		last_d = last_q;
		acc_d  = acc_q;
		seen_d = seen_q;
		need_d = need_q;
		flag_d = flag_q;
		act    = ACT_NONE;
		space  = SPACE_RAM;
		addr   = '0;
		cmd    = fold_case(byte_s1);

		if (mode_q == MODE_IDLE) begin
			if (byte_s1 >= CHR_SPACE) begin
				if (cmd == CMD_CONT) begin
					unique case (last_q)
						LAST_REGS, LAST_IRQS, LAST_WATCHES, LAST_FREE: begin
							cmd = CMD_REPEAT;
						end
						LAST_RAM, LAST_FLASH, LAST_EEPROM: begin
							acc_d = acc_q + PART_INC;
							cmd   = CMD_REPEAT;
						end
						LAST_TIMER: begin
							acc_d = tmr_next;
							cmd   = CMD_REPEAT;
						end
						default: begin
						end
					endcase
				end
				unique case (cmd)
					CMD_USAGE: act = ACT_USAGE;
					CMD_REGS: begin
						last_d = LAST_REGS;
						act    = ACT_REGS;
					end
					CMD_IRQS: begin
						last_d = LAST_IRQS;
						act    = ACT_IRQS;
					end
					CMD_WATCHES: begin
						last_d = LAST_WATCHES;
						act    = ACT_WATCHES;
					end
					CMD_FREE: begin
						last_d = LAST_FREE;
						act    = ACT_FREE_RAM;
					end
					CMD_RAM, CMD_FLASH, CMD_EEPROM, CMD_TIMER: begin
						acc_d  = '0;
						seen_d = '0;
						unique case (cmd)
							CMD_RAM: begin
								mode_d = MODE_RAM;
								need_d = ram_digits_q;
							end
							CMD_FLASH: begin
								mode_d = MODE_FLASH;
								need_d = flash_digits_q;
							end
							CMD_EEPROM: begin
								mode_d = MODE_EEPROM;
								need_d = eeprom_digits_q;
							end
							default: begin
								mode_d = MODE_TIMER;
								need_d = DIGIT_W'(1);
							end
						endcase
						// A digit count of zero is taken as one digit.
						if (need_d == '0) begin
							need_d = DIGIT_W'(1);
						end
					end
					CMD_REPEAT: begin
						unique case (last_q)
							LAST_REGS:    act = ACT_REGS;
							LAST_IRQS:    act = ACT_IRQS;
							LAST_WATCHES: act = ACT_WATCHES;
							LAST_FREE:    act = ACT_FREE_RAM;
							LAST_RAM: begin
								act   = ACT_MEM_DUMP;
								space = SPACE_RAM;
								addr  = acc_d;
							end
							LAST_FLASH: begin
								act   = ACT_MEM_DUMP;
								space = SPACE_FLASH;
								addr  = acc_d;
							end
							LAST_EEPROM: begin
								act   = ACT_MEM_DUMP;
								space = SPACE_EEPROM;
								addr  = acc_d;
							end
							LAST_TIMER: begin
								act  = ACT_TIMER_DUMP;
								addr = acc_d;
							end
							default: act = ACT_NONE;
						endcase
					end
					CMD_GO:   act = ACT_GO;
					CMD_STEP: act = ACT_STEP;
					CMD_NEXT: act = ACT_NEXT;
					CMD_ISR: begin
						flag_d = ~flag_q;
						act    = ACT_ISR_TOGGLE;
					end
					default: act = ACT_UNKNOWN;
				endcase
			end
		end else begin
			if (!hex[4]) begin
				// The partial address stays in the accumulator for a later repeat.
				act    = ACT_BAD_HEX;
				mode_d = MODE_IDLE;
			end else begin
				acc_d  = {acc_q[ADDR_BITS-5:0], hex[3:0]};
				seen_d = seen_q + 1'b1;
				if (seen_d == need_q) begin
					unique case (mode_q)
						MODE_TIMER: begin
							last_d = LAST_TIMER;
							act    = ACT_TIMER_DUMP;
						end
						MODE_RAM: begin
							last_d = LAST_RAM;
							act    = ACT_MEM_DUMP;
							space  = SPACE_RAM;
						end
						MODE_FLASH: begin
							last_d = LAST_FLASH;
							act    = ACT_MEM_DUMP;
							space  = SPACE_FLASH;
						end
						MODE_EEPROM: begin
							last_d = LAST_EEPROM;
							act    = ACT_MEM_DUMP;
							space  = SPACE_EEPROM;
						end
						default: begin
						end
					endcase
					addr   = acc_d;
					mode_d = MODE_IDLE;
				end
			end
		end
	end

	always_comb begin
		res.echo_byte    = byte_s1;
		res.action       = act;
		res.mem_space    = space;
		res.dump_address = DUMP_W'(addr);
		res.prompt       = (mode_d == MODE_IDLE);
		res.isr_debug_on = flag_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			last_q <= LAST_NONE;
			acc_q  <= '0;
			seen_q <= '0;
			need_q <= '0;
			flag_q <= 1'b1;
		end else if (step) begin
			mode_q <= mode_d;
			last_q <= last_d;
			acc_q  <= acc_d;
			seen_q <= seen_d;
			need_q <= need_d;
			flag_q <= flag_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_digits_q    <= RAM_DIGITS_RST;
			flash_digits_q  <= FLASH_DIGITS_RST;
			eeprom_digits_q <= EEPROM_DIGITS_RST;
			timer_count_q   <= TIMER_COUNT_RST;
		end else if (cfg.we) begin
			unique case (cfg.index)
				CFG_RAM_DIGITS:    ram_digits_q    <= cfg.wdata[DIGIT_W-1:0];
				CFG_FLASH_DIGITS:  flash_digits_q  <= cfg.wdata[DIGIT_W-1:0];
				CFG_EEPROM_DIGITS: eeprom_digits_q <= cfg.wdata[DIGIT_W-1:0];
				CFG_TIMER_COUNT:   timer_count_q   <= cfg.wdata[TCNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// While an address is being entered, fewer digits have arrived than are needed.
	`DMCP_ASSERT_IMPL(a_seen_below_need, mode_q != MODE_IDLE, (seen_q < need_q) && (need_q != '0))
	// A reported dump always leaves the parser at the prompt.
	`DMCP_ASSERT_IMPL(a_dump_ends_entry,
		step && (act == ACT_MEM_DUMP || act == ACT_TIMER_DUMP), mode_d == MODE_IDLE)
	// The ISR debug flag changes only with the toggle command.
	`DMCP_ASSERT_NEXT(a_flag_only_toggle, !(step && act == ACT_ISR_TOGGLE), $stable(flag_q))

endmodule

`default_nettype wire

// File: hw/rtl/debug_monitor_command_parser_unit.sv
// Debug monitor command parser: takes one received serial byte per transaction and returns one
// result per byte (echo, action code, memory space, dump address, prompt and ISR debug flag).
// A byte passes an input register and the decode in dmcp_core, and lands in a result register;
// a new byte is taken in every cycle while the sink does not stall, one byte per cycle sustained.
// The result register holds while the sink stalls, and the input register takes the next byte
// as soon as its byte moves on. Configuration writes take effect at once and are meant for
// when no byte is in flight. Depends on dmcp_pkg, dmcp_in_if, dmcp_out_if, dmcp_core and the
// assertion macros header.
`default_nettype none
`include "debug_monitor_command_parser_unit_defines.svh"

module debug_monitor_command_parser_unit #(
	parameter int unsigned ADDR_BITS = dmcp_pkg::ADDR_BITS_DEF,
	parameter int unsigned PART_LEN  = dmcp_pkg::PART_LEN_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire dmcp_pkg::cfg_idx_t            cfg_index,
	input  wire logic [dmcp_pkg::CFG_W-1:0]    cfg_wdata,
	dmcp_in_if.sink                            rx,
	dmcp_out_if.source                         tx
);
	import dmcp_pkg::*;

	logic              s1_valid_q;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_valid_q;
	result_t           out_q;
	result_t           res;
	cfg_wr_t           cfg;
	logic              advance;

	assign advance  = s1_valid_q && (!out_valid_q || tx.ready);
	assign rx.ready = !s1_valid_q || advance;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.wdata = cfg_wdata;

	dmcp_core #(
		.ADDR_BITS (ADDR_BITS),
		.PART_LEN  (PART_LEN)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step    (advance),
		.byte_s1 (byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (tx.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign tx.valid        = out_valid_q;
	assign tx.echo_byte    = out_q.echo_byte;
	assign tx.action       = out_q.action;
	assign tx.mem_space    = out_q.mem_space;
	assign tx.dump_address = out_q.dump_address;
	assign tx.prompt       = out_q.prompt;
	assign tx.isr_debug_on = out_q.isr_debug_on;

	// A byte in the input register is held until the result register can take it.
	`DMCP_ASSERT_NEXT(a_s1_held, s1_valid_q && !advance, s1_valid_q && $stable(byte_s1))

endmodule

`default_nettype wire

// File: bench/debug_monitor_command_parser_unit_test.sv
`timescale 1ns / 100ps
// Self-checking bench for debug_monitor_command_parser_unit: drives serial bytes and checks
// every result against a cycle-free model of the parser. Uses dmcp_pkg, dmcp_in_if, dmcp_out_if.

module debug_monitor_command_parser_unit_test;
	import dmcp_pkg::*;

	localparam int unsigned HOLD_CYCLES  = 60;
	localparam int unsigned PHASE_ITEMS  = 200;
	localparam int unsigned MAX_PRINTED  = 40;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	cfg_idx_t            cfg_index;
	logic [CFG_W-1:0]    cfg_wdata;

	dmcp_in_if  rx_ch ();
	dmcp_out_if tx_ch ();

	debug_monitor_command_parser_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.rx        (rx_ch),
		.tx        (tx_ch)
	);

	// Parser model: settings and state.
	logic [DIGIT_W-1:0]  ram_len, flash_len, eeprom_len;
	logic [TCNT_W-1:0]   timer_wrap;
	mode_t               cur_mode;
	last_t               cur_last;
	logic [DUMP_W-1:0]   cur_addr;
	logic [DIGIT_W-1:0]  got_digits, need_digits;
	logic                isr_flag;

	logic [BYTE_W-1:0]   rx_pending [$];
	result_t             replies_due [$];
	result_t             wanted;
	int unsigned         mismatches = 0;
	int unsigned         src_idle_pct, sink_idle_pct;
	bit                  hold_kick = 1'b0;
	bit                  hold_seen = 1'b0;
	int unsigned         hold_left;

	logic [BYTE_W-1:0]   simple_cmds [0:8] = '{CMD_USAGE, CMD_REGS, CMD_IRQS, CMD_WATCHES,
		CMD_FREE, CMD_GO, CMD_STEP, CMD_NEXT, CMD_ISR};

	function automatic int hex_nibble(input logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] lc;
		lc = (c >= CHR_UP_A && c <= CHR_UP_F) ? c + CASE_OFFSET : c;
		if (lc >= CHR_ZERO && lc <= CHR_NINE)
			return int'(lc - CHR_ZERO);
		if (lc >= CHR_LO_A && lc <= CHR_LO_F)
			return int'(lc - CHR_LO_A) + int'(HEX_TEN);
		return -1;
	endfunction

	function automatic void open_entry(input mode_t m, input logic [DIGIT_W-1:0] n);
		cur_mode    = m;
		cur_addr    = '0;
		got_digits  = '0;
		need_digits = (n == 0) ? 3'd1 : n;
	endfunction

	function automatic result_t predict_reply(input logic [BYTE_W-1:0] b);
		result_t           r;
		logic [BYTE_W-1:0] c;
		int                nv;
		r.echo_byte    = b;
		r.action       = ACT_NONE;
		r.mem_space    = SPACE_RAM;
		r.dump_address = '0;
		if (cur_mode == MODE_IDLE) begin
			if (b >= CHR_SPACE) begin
				c = (b >= CHR_UP_A && b <= CHR_UP_Z) ? b + CASE_OFFSET : b;
				// Continue steps a dump forward, then behaves as a repeat.
				if (c == CMD_CONT && cur_last != LAST_NONE) begin
					case (cur_last)
						LAST_RAM, LAST_FLASH, LAST_EEPROM: begin
							cur_addr = cur_addr + DUMP_W'(PART_LEN_DEF);
						end
						LAST_TIMER: begin
							cur_addr = cur_addr + 1'b1;
							if (cur_addr == timer_wrap)
								cur_addr = '0;
						end
						default: ;
					endcase
					c = CMD_REPEAT;
				end
				case (c)
					CMD_USAGE: r.action = ACT_USAGE;
					CMD_REGS: begin
						cur_last = LAST_REGS;
						r.action = ACT_REGS;
					end
					CMD_IRQS: begin
						cur_last = LAST_IRQS;
						r.action = ACT_IRQS;
					end
					CMD_WATCHES: begin
						cur_last = LAST_WATCHES;
						r.action = ACT_WATCHES;
					end
					CMD_FREE: begin
						cur_last = LAST_FREE;
						r.action = ACT_FREE_RAM;
					end
					CMD_RAM: open_entry(MODE_RAM, ram_len);
					CMD_FLASH: open_entry(MODE_FLASH, flash_len);
					CMD_EEPROM: open_entry(MODE_EEPROM, eeprom_len);
					CMD_TIMER: open_entry(MODE_TIMER, 3'd1);
					CMD_REPEAT: begin
						case (cur_last)
							LAST_REGS: r.action = ACT_REGS;
							LAST_IRQS: r.action = ACT_IRQS;
							LAST_WATCHES: r.action = ACT_WATCHES;
							LAST_FREE: r.action = ACT_FREE_RAM;
							LAST_RAM, LAST_FLASH, LAST_EEPROM: begin
								r.action       = ACT_MEM_DUMP;
								r.mem_space    = (cur_last == LAST_RAM) ? SPACE_RAM :
									(cur_last == LAST_FLASH) ? SPACE_FLASH : SPACE_EEPROM;
								r.dump_address = cur_addr;
							end
							LAST_TIMER: begin
								r.action       = ACT_TIMER_DUMP;
								r.dump_address = cur_addr;
							end
							default: ;
						endcase
					end
					CMD_GO: r.action = ACT_GO;
					CMD_STEP: r.action = ACT_STEP;
					CMD_NEXT: r.action = ACT_NEXT;
					CMD_ISR: begin
						isr_flag = ~isr_flag;
						r.action = ACT_ISR_TOGGLE;
					end
					default: r.action = ACT_UNKNOWN;
				endcase
			end
		end else begin
			nv = hex_nibble(b);
			if (nv < 0) begin
				// The partial address stays; a later repeat uses it.
				r.action = ACT_BAD_HEX;
				cur_mode = MODE_IDLE;
			end else begin
				cur_addr   = {cur_addr[DUMP_W-5:0], nv[3:0]};
				got_digits = got_digits + 1'b1;
				if (got_digits == need_digits) begin
					case (cur_mode)
						MODE_RAM: begin
							cur_last    = LAST_RAM;
							r.action    = ACT_MEM_DUMP;
							r.mem_space = SPACE_RAM;
						end
						MODE_FLASH: begin
							cur_last    = LAST_FLASH;
							r.action    = ACT_MEM_DUMP;
							r.mem_space = SPACE_FLASH;
						end
						MODE_EEPROM: begin
							cur_last    = LAST_EEPROM;
							r.action    = ACT_MEM_DUMP;
							r.mem_space = SPACE_EEPROM;
						end
						default: begin
							cur_last = LAST_TIMER;
							r.action = ACT_TIMER_DUMP;
						end
					endcase
					r.dump_address = cur_addr;
					cur_mode       = MODE_IDLE;
				end
			end
		end
		r.prompt       = (cur_mode == MODE_IDLE);
		r.isr_debug_on = isr_flag;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input int unsigned got,
		input int unsigned want);
		if (mismatches < MAX_PRINTED)
			$display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, field, got, want);
		mismatches++;
	endtask

	function automatic logic [BYTE_W-1:0] any_case(input logic [BYTE_W-1:0] c);
		if (c >= CHR_LO_A && $urandom_range(1) == 1)
			return c - CASE_OFFSET;
		return c;
	endfunction

	function automatic logic [BYTE_W-1:0] hex_char();
		int unsigned d;
		d = $urandom_range(15);
		if (d < HEX_TEN)
			return CHR_ZERO + BYTE_W'(d);
		return any_case(CHR_LO_A + BYTE_W'(d) - HEX_TEN);
	endfunction

	function automatic logic [BYTE_W-1:0] non_hex_byte();
		logic [BYTE_W-1:0] b;
		do
			b = BYTE_W'($urandom_range(255));
		while (hex_nibble(b) >= 0);
		return b;
	endfunction

	// Mostly complete commands with random content; the rest broken entries and noise.
	task automatic queue_random_commands(input int unsigned n_items);
		int unsigned        made, pick, digits, bad_at, k, reps;
		logic [BYTE_W-1:0]  cmd;
		made = 0;
		while (made < n_items) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				pick = $urandom_range(3);
				if (pick == 0) begin
					cmd    = CMD_RAM;
					digits = ram_len;
				end else if (pick == 1) begin
					cmd    = CMD_FLASH;
					digits = flash_len;
				end else if (pick == 2) begin
					cmd    = CMD_EEPROM;
					digits = eeprom_len;
				end else begin
					cmd    = CMD_TIMER;
					digits = 1;
				end
				if (digits == 0)
					digits = 1;
				bad_at = ($urandom_range(99) < 15) ? $urandom_range(digits - 1) : digits;
				rx_pending.push_back(any_case(cmd));
				made++;
				for (k = 0; k < digits && k <= bad_at; k++) begin
					rx_pending.push_back((k == bad_at) ? non_hex_byte() : hex_char());
					made++;
				end
			end else if (pick < 60) begin
				cmd  = ($urandom_range(1) == 1) ? CMD_CONT : CMD_REPEAT;
				reps = $urandom_range(1, 3);
				for (k = 0; k < reps; k++) begin
					rx_pending.push_back(any_case(cmd));
					made++;
				end
			end else if (pick < 85) begin
				rx_pending.push_back(any_case(simple_cmds[$urandom_range(8)]));
				made++;
			end else begin
				rx_pending.push_back(BYTE_W'($urandom_range(255)));
				made++;
			end
		end
	endtask

	task automatic write_setting(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_RAM_DIGITS: ram_len = val[DIGIT_W-1:0];
			CFG_FLASH_DIGITS: flash_len = val[DIGIT_W-1:0];
			CFG_EEPROM_DIGITS: eeprom_len = val[DIGIT_W-1:0];
			default: timer_wrap = val;
		endcase
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (rx_pending.size() != 0 || rx_ch.valid || replies_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_phase(input int unsigned ram, input int unsigned flash,
		input int unsigned eeprom, input int unsigned timers, input int unsigned src_pct,
		input int unsigned sink_pct, input bit long_hold, input bit addr_wrap);
		write_setting(CFG_RAM_DIGITS, CFG_W'(ram));
		write_setting(CFG_FLASH_DIGITS, CFG_W'(flash));
		write_setting(CFG_EEPROM_DIGITS, CFG_W'(eeprom));
		write_setting(CFG_TIMER_COUNT, CFG_W'(timers));
		@(negedge clk);
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		if (long_hold)
			hold_kick = ~hold_kick;
		if (addr_wrap) begin
			// Top of the address space, then continue must wrap to the bottom.
			rx_pending.push_back(CMD_RAM);
			repeat (5) rx_pending.push_back(CHR_LO_F);
			rx_pending.push_back(CMD_CONT);
		end
		queue_random_commands(PHASE_ITEMS);
		wait_drained();
	endtask

	// Sender: offers the next pending byte, predicting its result when it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_ch.valid   <= 1'b0;
			rx_ch.rx_byte <= '0;
		end else begin
			if (rx_ch.valid && rx_ch.ready)
				replies_due.push_back(predict_reply(rx_ch.rx_byte));
			if (!rx_ch.valid || rx_ch.ready) begin
				if (rx_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					rx_ch.valid   <= 1'b1;
					rx_ch.rx_byte <= rx_pending.pop_front();
				end else begin
					rx_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result transaction and drives ready, with an occasional long hold.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_ch.ready <= 1'b0;
			hold_left   <= 0;
		end else begin
			if (tx_ch.valid && tx_ch.ready) begin
				if (replies_due.size() == 0) begin
					report_mismatch("unexpected result, echo_byte", tx_ch.echo_byte, 0);
				end else begin
					wanted = replies_due.pop_front();
					if (tx_ch.echo_byte !== wanted.echo_byte)
						report_mismatch("echo_byte", tx_ch.echo_byte, wanted.echo_byte);
					if (tx_ch.action !== wanted.action)
						report_mismatch("action", tx_ch.action, wanted.action);
					if (tx_ch.mem_space !== wanted.mem_space)
						report_mismatch("mem_space", tx_ch.mem_space, wanted.mem_space);
					if (tx_ch.dump_address !== wanted.dump_address)
						report_mismatch("dump_address", tx_ch.dump_address,
							wanted.dump_address);
					if (tx_ch.prompt !== wanted.prompt)
						report_mismatch("prompt", tx_ch.prompt, wanted.prompt);
					if (tx_ch.isr_debug_on !== wanted.isr_debug_on)
						report_mismatch("isr_debug_on", tx_ch.isr_debug_on,
							wanted.isr_debug_on);
				end
			end
			if (hold_left != 0) begin
				tx_ch.ready <= 1'b0;
				hold_left   <= hold_left - 1;
			end else if (hold_kick != hold_seen) begin
				hold_seen   <= hold_kick;
				hold_left   <= HOLD_CYCLES;
				tx_ch.ready <= 1'b0;
			end else begin
				tx_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= CFG_RAM_DIGITS;
		cfg_wdata   <= '0;
		ram_len     = RAM_DIGITS_RST;
		flash_len   = FLASH_DIGITS_RST;
		eeprom_len  = EEPROM_DIGITS_RST;
		timer_wrap  = TIMER_COUNT_RST;
		cur_mode    = MODE_IDLE;
		cur_last    = LAST_NONE;
		cur_addr    = '0;
		got_digits  = '0;
		need_digits = '0;
		isr_flag    = 1'b1;
		src_idle_pct  = 26;
		sink_idle_pct = 53;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Opening sequence at reset settings: repeat and continue with nothing done yet,
		// control, high and space bytes, every command but flash, a continued RAM dump, a failed
		// entry followed by a repeat, and a timer index that wraps on continue.
		rx_pending = '{CMD_REPEAT, CMD_CONT, 8'h00, 8'h1f, 8'hff, CHR_SPACE, CMD_USAGE,
			CMD_REGS - CASE_OFFSET, CMD_CONT, CMD_IRQS, CMD_WATCHES, CMD_FREE,
			CMD_RAM, CHR_ZERO + 8'd1, CHR_UP_A, CHR_LO_F, CMD_CONT,
			CMD_EEPROM, CHR_NINE, CHR_UP_Z + CASE_OFFSET, CMD_REPEAT,
			CMD_TIMER, CHR_ZERO + 8'd2, CMD_CONT, CMD_GO, CMD_STEP, CMD_NEXT, CMD_ISR};
		wait_drained();

		run_phase(1, 1, 1, 1, 26, 53, 1'b1, 1'b0);
		run_phase(5, 5, 5, 15, 53, 26, 1'b0, 1'b1);
		run_phase(0, 6, 7, 0, 53, 26, 1'b0, 1'b0);
		run_phase($urandom_range(7), $urandom_range(7), $urandom_range(7), $urandom_range(15),
			0, 0, 1'b1, 1'b0);
		run_phase(2, 3, 4, 7, 0, 0, 1'b0, 1'b0);

		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
